[rtl/core/perceptron_train_classify_assert.svh]
// assertion macros for the perceptron block
// an empty body is used when the code goes to synthesis
`ifndef PERCEPTRON_TRAIN_CLASSIFY_ASSERT_SVH
`define PERCEPTRON_TRAIN_CLASSIFY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PTC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("perceptron assertion failed");

// next-cycle implication, checked out of reset
`define PTC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("perceptron assertion failed");

`else

`define PTC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define PTC_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[rtl/core/ptc_pkg.sv]
package ptc_pkg;

    // default sizing of the datapath
    localparam int NUM_FEATURES_DEF = 4;
    localparam int WORD_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF    = 8;

    // fixed widths of the beat fields
    localparam int FIELD_BITS = 16;
    localparam int IN_FIELDS  = 4;
    localparam int OP_BITS    = 2;
    localparam int LR_BITS    = 15;

    localparam logic [LR_BITS-1:0] LR_RESET = 15'd25;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_CLASSIFY = 2'd0;
    localparam logic [OP_BITS-1:0] OP_TRAIN    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_LOAD     = 2'd2;

    typedef struct packed {
        logic [OP_BITS-1:0]           op;
        logic signed [FIELD_BITS-1:0] feature_0;
        logic signed [FIELD_BITS-1:0] feature_1;
        logic signed [FIELD_BITS-1:0] feature_2;
        logic signed [FIELD_BITS-1:0] feature_3;
        logic                         label;
    } in_beat_t;

    typedef struct packed {
        logic                         prediction;
        logic                         mistake;
        logic signed [FIELD_BITS-1:0] weight_out_0;
        logic signed [FIELD_BITS-1:0] weight_out_1;
        logic signed [FIELD_BITS-1:0] weight_out_2;
        logic signed [FIELD_BITS-1:0] weight_out_3;
    } out_beat_t;

endpackage

[rtl/core/ptc_lane.sv]
module ptc_lane #(
    parameter int WORD_BITS = ptc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ptc_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             capture,
    input  logic signed [WORD_BITS-1:0]      weight,
    input  logic signed [WORD_BITS-1:0]      feature,
    input  logic signed [WORD_BITS-1:0]      err,
    input  logic [ptc_pkg::LR_BITS-1:0]      lr,
    output logic signed [WORD_BITS-1:0]      prod,
    output logic signed [WORD_BITS-1:0]      weight_upd
);

    localparam int LT_BITS = ptc_pkg::LR_BITS + WORD_BITS + 1;

    logic signed [2*WORD_BITS-1:0] wx_full;
    logic signed [2*WORD_BITS-1:0] ex_full;
    logic signed [LT_BITS-1:0]     lt_full;
    logic signed [WORD_BITS-1:0]   prod_reg;
    logic signed [WORD_BITS-1:0]   step_reg;
    logic signed [WORD_BITS-1:0]   delta;

    // weight times feature and error times feature, floor-scaled and wrapped
    assign wx_full = weight * feature;
    assign ex_full = err * feature;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            prod_reg <= WORD_BITS'(wx_full >>> FRAC_BITS);
            step_reg <= WORD_BITS'(ex_full >>> FRAC_BITS);
        end
    end

    // learning rate times the signed step, then added to the weight
    assign lt_full    = $signed({1'b0, lr}) * step_reg;
    assign delta      = WORD_BITS'(lt_full >>> FRAC_BITS);
    assign weight_upd = weight + delta;
    assign prod       = prod_reg;

endmodule

[rtl/core/ptc_merge.sv]
module ptc_merge #(
    parameter int NUM_FEATURES = ptc_pkg::NUM_FEATURES_DEF,
    parameter int WORD_BITS    = ptc_pkg::WORD_BITS_DEF
) (
    input  logic [NUM_FEATURES-1:0][WORD_BITS-1:0] prods,
    output logic                                   pred
);

    logic signed [WORD_BITS-1:0] sum;

    // wrapping sum of the lane products
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_FEATURES; i++)
        begin
            sum = sum + $signed(prods[i]);
        end
    end

    // class 1 only for a strictly positive sum
    assign pred = (sum > $signed(WORD_BITS'(0)));

endmodule

[rtl/core/perceptron_train_classify.sv]
// channel | direction | payload             | handshake
// in      | into      | ptc_pkg::in_beat_t  | in_valid / in_stall
// out     | out of    | ptc_pkg::out_beat_t | out_valid / out_stall
// lr_wr   | into      | learning rate       | lr_wr_en, no wait
//
// the lane multipliers run in the accept cycle and their products are registered;
// the sum, the compare and the learning-rate multiply-add run in the second step
// a new beat is taken only once the last one has written the weight registers,
// since the next dot product needs the updated weights
// reset clears the weights to zero and sets the learning rate to 25
// a stalled output holds the finished item, and the second step waits for it

`include "perceptron_train_classify_assert.svh"

module perceptron_train_classify #(
    parameter int NUM_FEATURES = ptc_pkg::NUM_FEATURES_DEF,
    parameter int WORD_BITS    = ptc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS    = ptc_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ptc_pkg::in_beat_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ptc_pkg::out_beat_t          out_data,
    input  logic                        lr_wr_en,
    input  logic [ptc_pkg::LR_BITS-1:0] lr_wr_data
);

    localparam int FB = ptc_pkg::FIELD_BITS;
    localparam int NI = ptc_pkg::IN_FIELDS;

    localparam logic signed [WORD_BITS-1:0] ONE_W     = WORD_BITS'(1 << FRAC_BITS);
    localparam logic signed [WORD_BITS-1:0] NEG_ONE_W = -ONE_W;

    logic signed [FB-1:0]          field_in   [NI];
    logic signed [WORD_BITS-1:0]   x_in       [NUM_FEATURES];
    logic signed [WORD_BITS-1:0]   x_reg      [NUM_FEATURES];
    logic signed [WORD_BITS-1:0]   weight_reg [NUM_FEATURES];
    logic signed [WORD_BITS-1:0]   weight_next[NUM_FEATURES];
    logic signed [WORD_BITS-1:0]   weight_upd [NUM_FEATURES];
    logic signed [FB-1:0]          out_w      [NI];
    logic [NUM_FEATURES-1:0][WORD_BITS-1:0] lane_prod;

    logic [ptc_pkg::LR_BITS-1:0] lr_reg;
    logic [ptc_pkg::OP_BITS-1:0] op_reg;
    logic                        label_reg;
    logic                        busy_reg;
    logic                        out_valid_reg;
    ptc_pkg::out_beat_t          out_data_reg;
    ptc_pkg::out_beat_t          out_next;

    logic                        accept;
    logic                        fire;
    logic                        pred;
    logic                        load_sel;
    logic                        train_sel;
    logic                        mistake_now;
    logic signed [WORD_BITS-1:0] err;

    // handshake: one item in flight, the output register frees the input side
    assign in_stall  = busy_reg;
    assign accept    = in_valid & ~busy_reg;
    assign fire      = busy_reg & (~out_valid_reg | ~out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // unpack the feature fields and size them to the word
    assign field_in[0] = in_data.feature_0;
    assign field_in[1] = in_data.feature_1;
    assign field_in[2] = in_data.feature_2;
    assign field_in[3] = in_data.feature_3;

    for (genvar i = 0; i < NUM_FEATURES; i++)
    begin : g_x
        if (i < NI)
        begin : g_field
            assign x_in[i] = WORD_BITS'(field_in[i]);
        end
        else
        begin : g_zero
            assign x_in[i] = '0;
        end
    end

    // error sign follows the label: it only matters on a mistake
    assign err = in_data.label ? ONE_W : NEG_ONE_W;

    // one lane per feature
    for (genvar i = 0; i < NUM_FEATURES; i++)
    begin : g_lane
        ptc_lane #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk        (clk),
            .capture    (accept),
            .weight     (weight_reg[i]),
            .feature    (x_in[i]),
            .err        (err),
            .lr         (lr_reg),
            .prod       (lane_prod[i]),
            .weight_upd (weight_upd[i])
        );
    end

    // sum the lanes and decide the class
    ptc_merge #(
        .NUM_FEATURES (NUM_FEATURES),
        .WORD_BITS    (WORD_BITS)
    ) u_merge (
        .prods (lane_prod),
        .pred  (pred)
    );

    // op decode
    always_comb
    begin
        load_sel  = 1'b0;
        train_sel = 1'b0;
        unique case (op_reg)
            ptc_pkg::OP_LOAD:     load_sel  = 1'b1;
            ptc_pkg::OP_TRAIN:    train_sel = 1'b1;
            ptc_pkg::OP_CLASSIFY: train_sel = 1'b0;
            default:              train_sel = 1'b0;
        endcase
    end

    assign mistake_now = train_sel & (pred != label_reg);

    // new weights: loaded, updated on a mistake, or kept
    always_comb
    begin
        for (int i = 0; i < NUM_FEATURES; i++)
        begin
            if (load_sel)
            begin
                weight_next[i] = x_reg[i];
            end
            else if (mistake_now)
            begin
                weight_next[i] = weight_upd[i];
            end
            else
            begin
                weight_next[i] = weight_reg[i];
            end
        end
    end

    // shown weights, resized to the field width
    for (genvar i = 0; i < NI; i++)
    begin : g_out
        if (i < NUM_FEATURES)
        begin : g_weight
            assign out_w[i] = FB'(weight_next[i]);
        end
        else
        begin : g_zero
            assign out_w[i] = '0;
        end
    end

    always_comb
    begin
        out_next.prediction   = pred & ~load_sel;
        out_next.mistake      = mistake_now;
        out_next.weight_out_0 = out_w[0];
        out_next.weight_out_1 = out_w[1];
        out_next.weight_out_2 = out_w[2];
        out_next.weight_out_3 = out_w[3];
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg        <= ptc_pkg::LR_RESET;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FEATURES; i++)
            begin
                weight_reg[i] <= '0;
            end
        end
        else
        begin
            if (lr_wr_en)
            begin
                lr_reg <= lr_wr_data;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire)
            begin
                busy_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_FEATURES; i++)
                begin
                    weight_reg[i] <= weight_next[i];
                end
            end
            else if (~out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_data.op;
            label_reg <= in_data.label;
            for (int i = 0; i < NUM_FEATURES; i++)
            begin
                x_reg[i] <= x_in[i];
            end
        end
        if (fire)
        begin
            out_data_reg <= out_next;
        end
    end

    // checks
    `PTC_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    `PTC_ASSERT_NEXT(a_fire_valid, clk, rst_n, fire, out_valid_reg)
    `PTC_ASSERT_NEXT(a_no_miss_untrained, clk, rst_n, fire && (op_reg != ptc_pkg::OP_TRAIN), !out_data_reg.mistake)
    `PTC_ASSERT_NEXT(a_load_no_pred, clk, rst_n, fire && (op_reg == ptc_pkg::OP_LOAD), !out_data_reg.prediction)
    `PTC_ASSERT_IMPLIES(a_busy_no_accept, clk, rst_n, busy_reg && !fire, !accept)

endmodule
